// ----- hdl/dbwc_pkg.sv -----
// shared types, constants and helpers for the delay-based window controller
package dbwc_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

	localparam int RTT_W      = 32;
	localparam int PROB_W     = 24;
	localparam int BETA_W     = 16;
	localparam int SC_W       = 7;
	localparam int WIN_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = PROB_W + RTT_W;

	localparam logic [BETA_W-1:0] BETA_RST         = BETA_W'(6554);
	localparam logic [PROB_W-1:0] P_MIN_RST        = PROB_W'(168);
	localparam logic [PROB_W-1:0] P_MAX_RST        = PROB_W'(1677722);
	localparam logic [SC_W-1:0]   SAMPLE_COUNT_RST = SC_W'(30);
	localparam logic [WIN_W-1:0]  INIT_WINDOW_RST  = WIN_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BETA         = 3'd0,
		CFG_P_MIN        = 3'd1,
		CFG_P_MAX        = 3'd2,
		CFG_SAMPLE_COUNT = 3'd3,
		CFG_INIT_WINDOW  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_CMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [RTT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROB_W-1:0] quotient;
	} div_rsp_t;

	// zero counts as one, anything past the ring depth counts as the depth
	function automatic logic [CNT_W-1:0] used_count(input logic [SC_W-1:0] sc);
		logic [CNT_W-1:0] n;
		if (sc == '0) begin
			n = CNT_W'(1);
		end else if (int'(sc) > MAX_SAMPLES) begin
			n = CNT_W'(MAX_SAMPLES);
		end else begin
			n = CNT_W'(sc);
		end
		return n;
	endfunction

endpackage

// ----- hdl/dbwc_sample_if.sv -----
// request channel carrying one received data item
interface dbwc_sample_if import dbwc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RTT_W-1:0]  rtt_ticks;
	logic              rtt_valid;
	logic [PROB_W-1:0] random_draw;

	modport source(output valid, rtt_ticks, rtt_valid, random_draw, input ready);
	modport sink(input valid, rtt_ticks, rtt_valid, random_draw, output ready);
endinterface

// ----- hdl/dbwc_result_if.sv -----
// request channel carrying one window update result
interface dbwc_result_if import dbwc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WIN_W-1:0] window_size;
	logic [WIN_W-1:0] slow_start_threshold;
	logic             decreased;
	logic             samples_full;

	modport source(output valid, window_size, slow_start_threshold, decreased, samples_full,
		input ready);
	modport sink(input valid, window_size, slow_start_threshold, decreased, samples_full,
		output ready);
endinterface

// ----- hdl/dbwc_ring_ram.sv -----
// single-port-write, single-port-read ram with registered read data
module dbwc_ring_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/dbwc_divider.sv -----
// restoring divider, one quotient bit per cycle, quotient known to fit PROB_W bits
module dbwc_divider import dbwc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(PROB_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [RTT_W-1:0]  rem_q;
	logic [RTT_W-1:0]  den_q;
	logic [PROB_W-1:0] num_q;
	logic [PROB_W-1:0] quo_q;

	logic [RTT_W:0]    shifted;
	logic [RTT_W:0]    trial;
	logic              qbit;

	always_comb begin
		shifted = {rem_q, num_q[PROB_W-1]};
		trial   = shifted - {1'b0, den_q};
		qbit    = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(PROB_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// upper dividend bits start below the divisor, so the remainder stays in RTT_W bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[PROD_W-1 -: RTT_W];
			num_q <= req.dividend[PROB_W-1:0];
			den_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? trial[RTT_W-1:0] : shifted[RTT_W-1:0];
			num_q <= {num_q[PROB_W-2:0], 1'b0};
			quo_q <= {quo_q[PROB_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- hdl/delay_based_window_controller_unit.sv -----
// top level: window/threshold update with rtt ring scan and probabilistic decrease
//
//   channel   dir  request fields                                       handshake
//   sample    in   rtt_ticks, rtt_valid, random_draw                    valid/ready
//   result    out  window_size, slow_start_threshold, decreased,        valid/ready
//                  samples_full
//   cfg       in   cfg_index, cfg_data                                  cfg_we
//
// items without a decrease check go from accept straight to the result load
// a checked item scans the ring one read per cycle; its pace is set by the single ram read port
// and the 24-step divider
// one item at a time; the result register lets the next request in while a result waits
// no clearing pass after reset: only ring entries written since reset are read
module delay_based_window_controller_unit import dbwc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	dbwc_sample_if.sink           sample,
	dbwc_result_if.source         result
);

	// configuration
	logic [BETA_W-1:0] beta_q;
	logic [PROB_W-1:0] p_min_q;
	logic [PROB_W-1:0] p_max_q;
	logic [SC_W-1:0]   sample_count_q;

	// scalar state
	logic [WIN_W-1:0]  window_q;
	logic [WIN_W-1:0]  thresh_q;
	logic [WIN_W-1:0]  avoid_cnt_q;
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  fill_q;

	// per-item working registers
	state_t            state_q;
	state_t            state_nxt;
	logic [RTT_W-1:0]  cur_q;
	logic [PROB_W-1:0] draw_q;
	logic              full_q;
	logic              dec_q;
	logic [RTT_W-1:0]  lo_q;
	logic [RTT_W-1:0]  hi_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [CNT_W-1:0]  scan_cnt_q;
	logic              rd_vld_s1;
	logic [PROD_W-1:0] prod_q;
	logic [RTT_W-1:0]  range_q;
	logic              div_start_q;
	logic [PROB_W-1:0] q_q;

	// result register
	logic              out_valid_q;
	logic [WIN_W-1:0]  out_window_q;
	logic [WIN_W-1:0]  out_thresh_q;
	logic              out_dec_q;
	logic              out_full_q;

	logic              accept;
	logic              scan_issue;
	logic              scan_done;
	logic              out_free;
	logic              out_load;
	logic              cut_en;
	logic [RTT_W-1:0]  rd_data;

	logic [CNT_W-1:0]  n_cnt;
	logic [CNT_W-1:0]  fill_clip;
	logic [CNT_W-1:0]  fill_next;
	logic              full_next;
	logic [WIN_W-1:0]  win_inc;
	logic [WIN_W-1:0]  win_grow;
	logic [WIN_W-1:0]  cnt_grow;

	logic [PROB_W-1:0] mag;
	logic [RTT_W-1:0]  rtt_diff;
	logic [PROB_W-1:0] prob;
	logic [BETA_W:0]   keep;
	logic [WIN_W+BETA_W:0] cut_prod;
	logic [WIN_W-1:0]  cut_win;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign accept = sample.valid && sample.ready;

	// fill bookkeeping and window growth for the item at the port
	always_comb begin
		n_cnt     = used_count(sample_count_q);
		fill_clip = (fill_q > n_cnt) ? n_cnt : fill_q;
		fill_next = (sample.rtt_valid && (fill_clip < n_cnt)) ?
			fill_clip + CNT_W'(1) : fill_clip;
		full_next = (fill_next >= n_cnt);

		win_inc = (window_q == '1) ? window_q : window_q + WIN_W'(1);
		if (window_q < thresh_q) begin
			win_grow = win_inc;
			cnt_grow = avoid_cnt_q;
		end else if (avoid_cnt_q >= window_q) begin
			win_grow = win_inc;
			cnt_grow = '0;
		end else begin
			win_grow = window_q;
			cnt_grow = avoid_cnt_q + WIN_W'(1);
		end
	end

	// probability and multiplicative cut
	always_comb begin
		mag      = (p_max_q >= p_min_q) ? p_max_q - p_min_q : p_min_q - p_max_q;
		rtt_diff = cur_q - lo_q;
		prob     = (p_max_q >= p_min_q) ? p_min_q + q_q : p_min_q - q_q;
		keep     = {1'b1, {BETA_W{1'b0}}} - {1'b0, beta_q};
		cut_prod = {{(BETA_W+1){1'b0}}, window_q} * {{WIN_W{1'b0}}, keep};
		cut_win  = cut_prod[WIN_W+BETA_W-1:BETA_W];
	end

	assign scan_done = (scan_cnt_q == fill_q) && !rd_vld_s1;
	assign out_free  = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = (sample.rtt_valid && full_next) ? ST_SCAN : ST_OUT;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				state_nxt = (hi_q == lo_q) ? ST_CMP : ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_nxt = ST_CMP;
				end
			end
			ST_CMP: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		sample.ready = 1'b0;
		scan_issue   = 1'b0;
		cut_en       = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: sample.ready = 1'b1;
			ST_SCAN: scan_issue   = (scan_cnt_q != fill_q);
			ST_CMP:  cut_en       = (draw_q < prob);
			ST_OUT:  out_load     = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q         <= BETA_RST;
			p_min_q        <= P_MIN_RST;
			p_max_q        <= P_MAX_RST;
			sample_count_q <= SAMPLE_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BETA:         beta_q         <= cfg_data[BETA_W-1:0];
				CFG_P_MIN:        p_min_q        <= cfg_data[PROB_W-1:0];
				CFG_P_MAX:        p_max_q        <= cfg_data[PROB_W-1:0];
				CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[SC_W-1:0];
				default: ;
			endcase
		end
	end

	// window, threshold and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= INIT_WINDOW_RST;
			thresh_q    <= '1;
			avoid_cnt_q <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			dec_q       <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == CFG_INIT_WINDOW)) begin
				window_q <= cfg_data[WIN_W-1:0];
			end else if (accept) begin
				window_q <= win_grow;
			end else if (cut_en) begin
				window_q <= cut_win;
			end
			if (cut_en) begin
				thresh_q <= cut_win;
			end
			if (accept) begin
				avoid_cnt_q <= cnt_grow;
				fill_q      <= fill_next;
				dec_q       <= 1'b0;
				if (sample.rtt_valid) begin
					head_q <= (head_q == ADDR_W'(MAX_SAMPLES - 1)) ? '0 : head_q + ADDR_W'(1);
				end
			end else if (cut_en) begin
				dec_q <= 1'b1;
			end
		end
	end

	// item capture and ring scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q  <= '0;
			rd_vld_s1   <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			rd_vld_s1   <= scan_issue;
			div_start_q <= (state_q == ST_MUL) && (hi_q != lo_q);
			if (accept) begin
				scan_cnt_q <= '0;
			end else if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q     <= sample.rtt_ticks;
			draw_q    <= sample.random_draw;
			full_q    <= full_next;
			rd_addr_q <= head_q;
			lo_q      <= '1;
			hi_q      <= '0;
		end else begin
			// walk back from the newest sample
			if (scan_issue) begin
				rd_addr_q <= (rd_addr_q == '0) ? ADDR_W'(MAX_SAMPLES - 1) :
					rd_addr_q - ADDR_W'(1);
			end
			if (rd_vld_s1) begin
				if (rd_data < lo_q) begin
					lo_q <= rd_data;
				end
				if (rd_data > hi_q) begin
					hi_q <= rd_data;
				end
			end
		end
		if (state_q == ST_MUL) begin
			prod_q  <= {{RTT_W{1'b0}}, mag} * {{PROB_W{1'b0}}, rtt_diff};
			range_q <= hi_q - lo_q;
			q_q     <= '0;
		end else if ((state_q == ST_DIV) && div_rsp.done) begin
			q_q <= div_rsp.quotient;
		end
	end

	dbwc_ring_ram #(
		.DEPTH (MAX_SAMPLES),
		.WIDTH (RTT_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (accept && sample.rtt_valid),
		.wr_addr (head_q),
		.wr_data (sample.rtt_ticks),
		.rd_en   (scan_issue),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	assign div_req.start    = div_start_q;
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = range_q;

	dbwc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_window_q <= window_q;
			out_thresh_q <= thresh_q;
			out_dec_q    <= dec_q;
			out_full_q   <= full_q;
		end
	end

	assign result.valid                = out_valid_q;
	assign result.window_size          = out_window_q;
	assign result.slow_start_threshold = out_thresh_q;
	assign result.decreased            = out_dec_q;
	assign result.samples_full         = out_full_q;

	a_dec_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.decreased) |-> result.samples_full)
		else $error("decrease reported without a full sample ring");

	a_dec_sets_thresh: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.decreased) |->
		(result.window_size == result.slow_start_threshold))
		else $error("threshold does not follow the cut window");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide step");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_SAMPLES))
		else $error("ring fill count beyond ring depth");

endmodule

// ----- dv/delay_based_window_controller_unit_test.sv -----
// testbench for the delay-based window controller: directed and random requests, scored on the fly
module delay_based_window_controller_unit_test import dbwc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 100;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 57;
	localparam int PEND_DEPTH   = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_BASE = CFG_IDX_W'(CFG_INIT_WINDOW) + 1'b1;

	typedef struct {
		logic [WIN_W-1:0] window_size;
		logic [WIN_W-1:0] slow_start_threshold;
		logic             decreased;
		logic             samples_full;
	} window_update_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dbwc_sample_if sample_ch ();
	dbwc_result_if result_ch ();

	delay_based_window_controller_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	// register copies
	logic [BETA_W-1:0] cfg_beta;
	logic [PROB_W-1:0] cfg_p_min;
	logic [PROB_W-1:0] cfg_p_max;
	logic [SC_W-1:0]   cfg_sample_count;

	// predicted controller state
	logic [WIN_W-1:0]  exp_window;
	logic [WIN_W-1:0]  exp_threshold;
	logic [WIN_W-1:0]  exp_avoid_count;
	logic [RTT_W-1:0]  rtt_hist [MAX_SAMPLES];
	logic [ADDR_W-1:0] hist_head;
	logic [CNT_W-1:0]  hist_fill;

	// predictions waiting for their result, kept in order
	window_update_t pending_updates [PEND_DEPTH];
	int pend_wr;
	int pend_rd;

	int fail_count;
	int samples_sent;
	int results_checked;
	int cuts_seen;
	int reg_writes;
	int cycle_count;
	int burst_left;
	bit no_gaps;
	int hold_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pend_wr - pend_rd);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [CNT_W-1:0] effective_depth(input logic [SC_W-1:0] sc);
		if (sc == '0) begin
			return CNT_W'(1);
		end
		if (int'(sc) > MAX_SAMPLES) begin
			return CNT_W'(MAX_SAMPLES);
		end
		return CNT_W'(sc);
	endfunction

	// probability from where cur sits between the min and max of the recent samples
	function automatic logic [PROB_W-1:0] decrease_prob(input logic [RTT_W-1:0] cur);
		logic [RTT_W-1:0]  lo;
		logic [RTT_W-1:0]  hi;
		logic [ADDR_W-1:0] idx;
		logic [63:0]       mag;
		logic [63:0]       q;
		int                k;
		lo = '1;
		hi = '0;
		idx = hist_head;
		for (k = 0; k < int'(hist_fill); k++) begin
			idx = idx - 1'b1;
			if (rtt_hist[idx] < lo) begin
				lo = rtt_hist[idx];
			end
			if (rtt_hist[idx] > hi) begin
				hi = rtt_hist[idx];
			end
		end
		if (hi == lo) begin
			return cfg_p_min;
		end
		mag = (cfg_p_max >= cfg_p_min) ? 64'(cfg_p_max - cfg_p_min) : 64'(cfg_p_min - cfg_p_max);
		q = mag * 64'(cur - lo) / 64'(hi - lo);
		if (cfg_p_max >= cfg_p_min) begin
			return cfg_p_min + PROB_W'(q);
		end
		return cfg_p_min - PROB_W'(q);
	endfunction

	function automatic window_update_t predict_window_update(input logic [RTT_W-1:0] rtt,
		input logic used, input logic [PROB_W-1:0] draw);
		window_update_t   upd;
		logic [CNT_W-1:0] n;
		logic             cut;
		n = effective_depth(cfg_sample_count);
		cut = 1'b0;
		if (exp_window < exp_threshold) begin
			if (exp_window != '1) begin
				exp_window++;
			end
		end else if (exp_avoid_count >= exp_window) begin
			if (exp_window != '1) begin
				exp_window++;
			end
			exp_avoid_count = '0;
		end else begin
			exp_avoid_count++;
		end
		// a lowered depth keeps only the newest samples
		if (hist_fill > n) begin
			hist_fill = n;
		end
		if (used) begin
			rtt_hist[hist_head] = rtt;
			hist_head = hist_head + 1'b1;
			if (hist_fill < n) begin
				hist_fill++;
			end
			if (hist_fill >= n && draw < decrease_prob(rtt)) begin
				exp_window = WIN_W'((64'(exp_window) * (64'd65536 - 64'(cfg_beta))) >> 16);
				exp_threshold = exp_window;
				cut = 1'b1;
			end
		end
		upd.window_size = exp_window;
		upd.slow_start_threshold = exp_threshold;
		upd.decreased = cut;
		upd.samples_full = (hist_fill >= n);
		return upd;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(15, 120);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BETA: cfg_beta = data[BETA_W-1:0];
			CFG_P_MIN: cfg_p_min = data[PROB_W-1:0];
			CFG_P_MAX: cfg_p_max = data[PROB_W-1:0];
			CFG_SAMPLE_COUNT: cfg_sample_count = data[SC_W-1:0];
			CFG_INIT_WINDOW: exp_window = data[WIN_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic send_sample(input logic [RTT_W-1:0] rtt, input logic used,
		input logic [PROB_W-1:0] draw);
		int gap;
		if (no_gaps) begin
			gap = 0;
		end else if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 39) == 0) begin
			burst_left = $urandom_range(20, 40);
			gap = 0;
		end else begin
			gap = idle_len();
		end
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.rtt_ticks <= rtt;
		sample_ch.rtt_valid <= used;
		sample_ch.random_draw <= draw;
		do @(posedge clk); while (!sample_ch.ready);
		pending_updates[pend_wr % PEND_DEPTH] = predict_window_update(rtt, used, draw);
		pend_wr++;
		samples_sent++;
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (pend_wr != pend_rd) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic check_reset_growth();
		send_sample('0, 1'b1, '0);
		send_sample('1, 1'b1, '1);
		send_sample(32'd1234, 1'b0, '0);
		send_sample(32'hA5A5_5A5A, 1'b1, 24'h00_0001);
		send_sample(32'd77, 1'b0, '1);
		wait_idle();
	endtask

	task automatic check_window_saturation();
		// threshold is still unset, so the window climbs to all ones and holds there
		write_reg(CFG_INIT_WINDOW, 32'hFFFF_FFFD);
		send_sample(32'd10, 1'b0, '0);
		send_sample(32'd10, 1'b0, '0);
		send_sample(32'd10, 1'b0, '0);
		wait_idle();
		write_reg(CFG_SAMPLE_COUNT, 32'd1);
		write_reg(CFG_P_MIN, 32'h00FF_FFFF);
		write_reg(CFG_P_MAX, 32'h00FF_FFFF);
		send_sample(32'd20, 1'b1, '0);
		wait_idle();
	endtask

	task automatic check_equal_extremes();
		write_reg(CFG_INIT_WINDOW, 32'd40);
		write_reg(CFG_SAMPLE_COUNT, 32'd3);
		write_reg(CFG_P_MIN, 32'h0080_0000);
		write_reg(CFG_P_MAX, 32'h00FF_FFFF);
		send_sample(32'd500, 1'b1, '0);
		send_sample(32'd500, 1'b1, '0);
		// flat ring: p is p_min, so a draw one below cuts and p_min itself does not
		send_sample(32'd500, 1'b1, 24'h7F_FFFF);
		send_sample(32'd500, 1'b1, 24'h80_0000);
		send_sample(32'd900, 1'b1, 24'hFF_FFFE);
		wait_idle();
	endtask

	task automatic check_depth_limits();
		int j;
		for (j = 0; j < 3; j++) begin
			write_reg(CFG_IDX_W'(CFG_SPARE_BASE + j), $urandom());
		end
		write_reg(CFG_P_MIN, 32'h0010_0000);
		write_reg(CFG_P_MAX, 32'h00F0_0000);
		write_reg(CFG_SAMPLE_COUNT, 32'd0);
		send_sample(32'd7, 1'b1, '1);
		send_sample(32'd9, 1'b1, '0);
		wait_idle();
		write_reg(CFG_SAMPLE_COUNT, 32'd8);
		send_sample(32'd300, 1'b1, '0);
		send_sample(32'd100, 1'b0, '0);
		send_sample(32'd200, 1'b1, '0);
		wait_idle();
		// fill clipped down to the new depth
		write_reg(CFG_SAMPLE_COUNT, 32'd2);
		send_sample(32'd250, 1'b1, '0);
		send_sample(32'd150, 1'b1, 24'h10_0000);
		wait_idle();
	endtask

	task automatic check_cut_to_zero();
		write_reg(CFG_BETA, 32'h0000_FFFF);
		write_reg(CFG_P_MIN, 32'h00FF_FFFF);
		write_reg(CFG_P_MAX, 32'h00FF_FFFF);
		write_reg(CFG_SAMPLE_COUNT, 32'd1);
		write_reg(CFG_INIT_WINDOW, 32'd3);
		send_sample(32'd40, 1'b1, '0);
		send_sample(32'd40, 1'b0, '0);
		send_sample(32'd41, 1'b1, '0);
		wait_idle();
	endtask

	task automatic write_all_regs(input logic [BETA_W-1:0] beta, input logic [PROB_W-1:0] pmin,
		input logic [PROB_W-1:0] pmax, input logic [SC_W-1:0] sc, input logic [WIN_W-1:0] win);
		// junk above each field must be dropped
		write_reg(CFG_BETA, {16'($urandom()), beta});
		write_reg(CFG_P_MIN, {8'($urandom()), pmin});
		write_reg(CFG_P_MAX, {8'($urandom()), pmax});
		write_reg(CFG_SAMPLE_COUNT, {25'($urandom()), sc});
		write_reg(CFG_INIT_WINDOW, win);
	endtask

	task automatic send_random_samples(input int count, input logic [RTT_W-1:0] base,
		input logic [RTT_W-1:0] spread);
		logic [RTT_W-1:0]  rtt;
		logic [PROB_W-1:0] draw;
		logic [PROB_W-1:0] p_hi;
		logic              used;
		int                i;
		p_hi = (cfg_p_max > cfg_p_min) ? cfg_p_max : cfg_p_min;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				rtt = $urandom();
			end else begin
				rtt = base + RTT_W'($urandom_range(0, spread));
			end
			used = ($urandom_range(0, 99) < 85);
			if ($urandom_range(0, 1) == 0) begin
				draw = PROB_W'($urandom_range(0, 24'hFF_FFFF));
			end else begin
				draw = PROB_W'($urandom_range(0, p_hi));
			end
			send_sample(rtt, used, draw);
		end
	endtask

	task automatic check_backpressure();
		// receiver holds off while requests keep coming with no gaps
		write_all_regs(16'd8000, 24'h40_0000, 24'hC0_0000, 7'd4, 32'd16);
		no_gaps = 1'b1;
		hold_req++;
		send_random_samples(12, 32'd1000, 32'd200);
		no_gaps = 1'b0;
		wait_idle();
	endtask

	task automatic check_random_phases();
		logic [BETA_W-1:0] beta;
		logic [PROB_W-1:0] pmin;
		logic [PROB_W-1:0] pmax;
		logic [SC_W-1:0]   sc;
		logic [WIN_W-1:0]  win;
		logic [RTT_W-1:0]  spread;
		int                ph;
		for (ph = 0; ph < PHASES; ph++) begin
			beta = BETA_W'($urandom());
			pmin = PROB_W'($urandom());
			pmax = PROB_W'($urandom());
			sc = ($urandom_range(0, 9) < 7) ? SC_W'($urandom_range(1, 16)) :
				SC_W'($urandom_range(0, 127));
			win = ($urandom_range(0, 1) == 0) ? WIN_W'($urandom_range(1, 64)) : WIN_W'($urandom());
			case (ph)
				0: begin
					beta = '0;
					pmin = '0;
					pmax = '1;
					sc = SC_W'(MAX_SAMPLES);
					win = WIN_W'(1);
				end
				1: begin
					beta = '1;
					pmin = '1;
					pmax = '0;
					sc = SC_W'(1);
					win = '1;
				end
				2: sc = '1;
				default: ;
			endcase
			case ($urandom_range(0, 3))
				0: spread = '0;
				1: spread = RTT_W'(15);
				2: spread = RTT_W'(5000);
				default: spread = RTT_W'(32'hF_FFFF);
			endcase
			write_all_regs(beta, pmin, pmax, sc, win);
			send_random_samples(PHASE_ITEMS, $urandom(), spread);
			wait_idle();
		end
	endtask

	// result ready: random runs and stalls, plus a long hold when asked
	initial begin
		int hold_seen;
		int hold_left;
		int run_left;
		int stall_left;
		hold_seen = 0;
		hold_left = 0;
		run_left = 0;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (run_left == 0 && stall_left == 0) begin
				run_left = ($urandom_range(0, 99) < 8) ? $urandom_range(100, 200) :
					$urandom_range(1, 6);
				stall_left = idle_len();
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (run_left > 0) begin
				result_ch.ready <= 1'b1;
				run_left--;
			end else begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end
		end
	end

	always @(posedge clk) begin : result_check
		window_update_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pend_wr == pend_rd) begin
				$error("result with no request outstanding: window_size %0h",
					result_ch.window_size);
				fail_count++;
			end else begin
				want = pending_updates[pend_rd % PEND_DEPTH];
				pend_rd++;
				results_checked++;
				if (result_ch.decreased === 1'b1) begin
					cuts_seen++;
				end
				if (result_ch.window_size !== want.window_size) begin
					$error("window_size: expected %0h, got %0h", want.window_size,
						result_ch.window_size);
					fail_count++;
				end
				if (result_ch.slow_start_threshold !== want.slow_start_threshold) begin
					$error("slow_start_threshold: expected %0h, got %0h",
						want.slow_start_threshold, result_ch.slow_start_threshold);
					fail_count++;
				end
				if (result_ch.decreased !== want.decreased) begin
					$error("decreased: expected %0b, got %0b", want.decreased,
						result_ch.decreased);
					fail_count++;
				end
				if (result_ch.samples_full !== want.samples_full) begin
					$error("samples_full: expected %0b, got %0b", want.samples_full,
						result_ch.samples_full);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.rtt_ticks <= '0;
		sample_ch.rtt_valid <= 1'b0;
		sample_ch.random_draw <= '0;
		cfg_beta = BETA_RST;
		cfg_p_min = P_MIN_RST;
		cfg_p_max = P_MAX_RST;
		cfg_sample_count = SAMPLE_COUNT_RST;
		exp_window = INIT_WINDOW_RST;
		exp_threshold = '1;
		exp_avoid_count = '0;
		hist_head = '0;
		hist_fill = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_growth();
		check_window_saturation();
		check_equal_extremes();
		check_depth_limits();
		check_cut_to_zero();
		check_backpressure();
		check_random_phases();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d requests through %0d register writes, %0d results compared",
			samples_sent, reg_writes, results_checked);
		$display("%0d window cuts seen, %0d mismatches", cuts_seen, fail_count);
		if (fail_count == 0 && pend_wr == pend_rd) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/dbwc_pkg.sv
hdl/dbwc_sample_if.sv
hdl/dbwc_result_if.sv
hdl/dbwc_ring_ram.sv
hdl/dbwc_divider.sv
hdl/delay_based_window_controller_unit.sv
dv/delay_based_window_controller_unit_test.sv
